>>> src/mtt_pkg.sv
// Shared types, character constants and scan functions for the markup tag tokenizer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

  localparam int LINE_BITS     = 20;
  localparam int POSITION_BITS = 24;
  localparam int MAX_RESULTS   = 3;
  localparam int CNT_BITS      = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_BITS     = $clog2(MAX_RESULTS);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef logic [LINE_BITS-1:0]     line_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;

  typedef enum logic [2:0] {
    TK_OPEN       = 3'd0,
    TK_CLOSE      = 3'd1,
    TK_LITERAL    = 3'd2,
    TK_NAME_CHAR  = 3'd3,
    TK_NAME_END   = 3'd4,
    TK_GT         = 3'd5,
    TK_SELF_CLOSE = 3'd6
  } token_kind_t;

  typedef enum logic [1:0] {
    MODE_OUT        = 2'd0,
    MODE_NAME       = 2'd1,
    MODE_SKIP_SLASH = 2'd2,
    MODE_SKIP_GT    = 2'd3
  } scan_mode_t;

  typedef struct packed {
    token_kind_t kind;
    logic [7:0]  name_byte;
    line_t       line;
    pos_t        pos;
  } token_t;

  // Up to three tokens from the held byte (and last byte at end), in delivery order.
  typedef struct packed {
    cnt_t                      cnt;
    token_t [MAX_RESULTS-1:0]  slot;
  } group_t;

  // Outcome of judging one byte: next mode and zero, one or two token kinds.
  typedef struct packed {
    scan_mode_t  mode;
    logic [1:0]  cnt;
    token_kind_t k0;
    token_kind_t k1;
    logic [7:0]  name;
  } judge_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic line_t sat_inc_line(input line_t x);
    return (x == '1) ? x : x + line_t'(1);
  endfunction

  function automatic pos_t sat_inc_pos(input pos_t x);
    return (x == '1) ? x : x + pos_t'(1);
  endfunction

  function automatic judge_t judge(input scan_mode_t mode, input logic [7:0] c,
                                   input logic [7:0] la, input logic has_la);
    judge_t r;
    logic   la_gt;
    la_gt  = has_la && (la == CH_GT);
    r.mode = mode;
    r.cnt  = 2'd0;
    r.k0   = TK_OPEN;
    r.k1   = TK_OPEN;
    r.name = 8'h00;
    unique case (mode)
      MODE_OUT: begin
        if (c == CH_LT) begin
          r.cnt = 2'd1;
          if (has_la && la == CH_SLASH) begin
            r.k0   = TK_CLOSE;
            r.mode = MODE_SKIP_SLASH;
          end else if (!has_la || is_digit(la) || is_ws(la)) begin
            r.k0 = TK_LITERAL;
          end else begin
            r.k0   = TK_OPEN;
            r.mode = MODE_NAME;
          end
        end else if (c == CH_GT) begin
          r.cnt = 2'd1;
          r.k0  = TK_GT;
        end else if (c == CH_SLASH && la_gt) begin
          r.cnt  = 2'd1;
          r.k0   = TK_SELF_CLOSE;
          r.mode = MODE_SKIP_GT;
        end
      end
      MODE_NAME: begin
        if (is_alpha(c)) begin
          r.cnt  = 2'd1;
          r.k0   = TK_NAME_CHAR;
          r.name = c;
        end else if (is_ws(c)) begin
          r.cnt  = 2'd1;
          r.k0   = TK_NAME_END;
          r.mode = MODE_OUT;
        end else if (c == CH_GT) begin
          r.cnt  = 2'd2;
          r.k0   = TK_NAME_END;
          r.k1   = TK_GT;
          r.mode = MODE_OUT;
        end else if (c == CH_SLASH && la_gt) begin
          r.cnt  = 2'd2;
          r.k0   = TK_NAME_END;
          r.k1   = TK_SELF_CLOSE;
          r.mode = MODE_SKIP_GT;
        end
      end
      MODE_SKIP_SLASH: r.mode = MODE_NAME;
      MODE_SKIP_GT:    r.mode = MODE_OUT;
      default:         r.mode = MODE_OUT;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/mtt_if.sv
// Valid/ready channel interfaces for the tokenizer's text input and token output.
// Depends on mtt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mtt_in_if import mtt_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface mtt_out_if import mtt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [2:0]               token_kind;
  logic [7:0]               name_byte;
  logic [LINE_BITS-1:0]     line_number;
  logic [POSITION_BITS-1:0] byte_position;
  logic                     final_result;

  modport source(output valid, output token_kind, output name_byte, output line_number,
                 output byte_position, output final_result, input ready);
  modport sink(input valid, input token_kind, input name_byte, input line_number,
               input byte_position, input final_result, output ready);
endinterface

`default_nettype wire

>>> src/mtt_result_buf.sv
// Result register: holds one token group and hands it out one token per handshake.
// Depends on mtt_pkg and mtt_out_if.
`timescale 1ns / 1ps
`default_nettype none

module mtt_result_buf import mtt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load,
  input  wire group_t grp_in,
  output logic        can_load,
  mtt_out_if.source   out_ch
);

  group_t                grp_r;
  cnt_t                  cnt_r, cnt_nxt;
  logic [SLOT_BITS-1:0]  idx_r, idx_nxt;
  token_t                head;
  logic                  is_final;
  logic                  pop;
  logic                  last_pop;

  assign head     = grp_r.slot[idx_r];
  assign is_final = (cnt_t'(idx_r) == cnt_r - cnt_t'(1));
  assign pop      = out_ch.valid && out_ch.ready;
  assign last_pop = pop && is_final;
  assign can_load = (cnt_r == '0) || last_pop;

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.token_kind    = head.kind;
  assign out_ch.name_byte     = head.name_byte;
  assign out_ch.line_number   = head.line;
  assign out_ch.byte_position = head.pos;
  assign out_ch.final_result  = is_final;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load && grp_in.cnt != '0) begin
      cnt_nxt = grp_in.cnt;
      idx_nxt = '0;
    end else if (last_pop) begin
      cnt_nxt = '0;
      idx_nxt = '0;
    end else if (pop) begin
      idx_nxt = idx_r + SLOT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && grp_in.cnt != '0) begin
      grp_r <= grp_in;
    end
  end

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (cnt_t'(idx_r) < cnt_r))
    else $error("result index beyond group size");

  a_step_next: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !is_final && !load) |=> (out_ch.valid && idx_r == $past(idx_r) + SLOT_BITS'(1)))
    else $error("group did not advance to its next token");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load && grp_in.cnt != '0) |-> can_load)
    else $error("token group loaded over an undelivered one");

endmodule

`default_nettype wire

>>> src/markup_tag_tokenizer_unit.sv
// A byte waits in the input register s1, then in the held-byte register, where it is
// judged against the byte that follows it once that byte is in s1. Throughput: one byte
// per cycle while each byte yields at most one token and out_ch is ready; a byte that
// yields k tokens holds the single result register until all k tokens are taken.
// Reset (synchronous, active low): no held byte, outside any tag, line 1, position 0.
// Top level of the markup tag tokenizer; depends on mtt_pkg, mtt_if and mtt_result_buf.
`timescale 1ns / 1ps
`default_nettype none

module markup_tag_tokenizer_unit import mtt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mtt_in_if.sink    in_ch,
  mtt_out_if.source out_ch
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eot_r;

  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_r, held_nxt;
  scan_mode_t mode_r, mode_nxt;
  line_t      line_r, line_nxt;
  pos_t       pos_r, pos_nxt;

  logic       can_load;
  logic       s1_go;
  judge_t     ja, jb;
  scan_mode_t mode_a;
  line_t      line_a, line_b;
  pos_t       pos_a, pos_b;
  group_t     grp;
  token_t     cand [5];
  logic [4:0] cand_v;
  cnt_t       fill;

  assign s1_go       = s1_valid_r && can_load;
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.text_byte;
      s1_eot_r  <= in_ch.end_of_text;
    end
  end

  // The held byte is judged with the new byte as lookahead; on the last byte the new
  // byte is judged too, with no lookahead.
  always_comb begin
    ja     = judge(mode_r, held_r, s1_byte_r, 1'b1);
    mode_a = held_valid_r ? ja.mode : mode_r;
    pos_a  = held_valid_r ? sat_inc_pos(pos_r) : pos_r;
    line_a = (held_valid_r && held_r == CH_LF) ? sat_inc_line(line_r) : line_r;
    jb     = judge(mode_a, s1_byte_r, 8'h00, 1'b0);
    pos_b  = sat_inc_pos(pos_a);
    line_b = (s1_byte_r == CH_LF) ? sat_inc_line(line_a) : line_a;
  end

  always_comb begin
    cand[0] = '{kind: ja.k0, name_byte: ja.name, line: line_a, pos: pos_a};
    cand[1] = '{kind: ja.k1, name_byte: 8'h00, line: line_a, pos: pos_a};
    cand[2] = '{kind: jb.k0, name_byte: jb.name, line: line_b, pos: pos_b};
    cand[3] = '{kind: jb.k1, name_byte: 8'h00, line: line_b, pos: pos_b};
    cand[4] = '{kind: TK_NAME_END, name_byte: 8'h00, line: line_b, pos: pos_b};
    cand_v[0] = held_valid_r && (ja.cnt != 2'd0);
    cand_v[1] = held_valid_r && (ja.cnt == 2'd2);
    cand_v[2] = s1_eot_r && (jb.cnt != 2'd0);
    cand_v[3] = s1_eot_r && (jb.cnt == 2'd2);
    cand_v[4] = s1_eot_r && (jb.mode == MODE_NAME);
    grp  = '0;
    fill = '0;
    for (int i = 0; i < 5; i++) begin
      if (cand_v[i] && fill < cnt_t'(MAX_RESULTS)) begin
        grp.slot[fill[SLOT_BITS-1:0]] = cand[i];
        fill = fill + cnt_t'(1);
      end
    end
    grp.cnt = fill;
  end

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    mode_nxt       = mode_r;
    line_nxt       = line_r;
    pos_nxt        = pos_r;
    if (s1_go) begin
      if (s1_eot_r) begin
        held_valid_nxt = 1'b0;
        held_nxt       = 8'h00;
        mode_nxt       = MODE_OUT;
        line_nxt       = line_t'(1);
        pos_nxt        = '0;
      end else begin
        held_valid_nxt = 1'b1;
        held_nxt       = s1_byte_r;
        mode_nxt       = mode_a;
        line_nxt       = line_a;
        pos_nxt        = pos_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_r       <= 8'h00;
      mode_r       <= MODE_OUT;
      line_r       <= line_t'(1);
      pos_r        <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_r       <= held_nxt;
      mode_r       <= mode_nxt;
      line_r       <= line_nxt;
      pos_r        <= pos_nxt;
    end
  end

  mtt_result_buf u_result_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_go),
    .grp_in   (grp),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  a_skip_slash_held: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SKIP_SLASH) |-> (held_valid_r && held_r == CH_SLASH))
    else $error("close tag skip without a held slash");

  a_skip_gt_held: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SKIP_GT) |-> (held_valid_r && held_r == CH_GT))
    else $error("self-close skip without a held '>'");

  // The held byte is only counted once it is judged, so an empty hold means a fresh text.
  a_idle_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    !held_valid_r |-> (mode_r == MODE_OUT && pos_r == '0))
    else $error("scan state moved without a held byte");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_eot_r) |=> (!held_valid_r && mode_r == MODE_OUT && pos_r == '0))
    else $error("scan state not restarted after the last byte");

endmodule

`default_nettype wire
